@@ src/rau_pkg.sv @@
package rau_pkg;

    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 30;

    localparam logic [RES_NUM_W-2:0] NUM_SAT = 31'h7FFF_FFFF;
    localparam logic [RES_DEN_W-1:0] DEN_SAT = 30'h3FFF_FFFF;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_GT  = 4'd4,
        OP_LT  = 4'd5,
        OP_GE  = 4'd6,
        OP_LE  = 4'd7,
        OP_EQ  = 4'd8,
        OP_NE  = 4'd9
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_MUL_P,
        ST_MUL_D,
        ST_SETUP,
        ST_GCD,
        ST_DIV_N,
        ST_DIV_D,
        ST_FIN
    } state_t;

endpackage

@@ src/rau_divider.sv @@
module rau_divider #(
    parameter int WIDTH = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;

    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   diff;
    logic             borrow;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        borrow    = diff[WIDTH];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = borrow ? rem_shift[WIDTH-1:0] : diff[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], ~borrow};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/rational_arithmetic_unit.sv @@
// Rational arithmetic unit.
// Input requests arrive on the s_ stream: s_tuser carries the operation code,
// s_tdata the two fractions a and b. One result request leaves on the m_ stream
// per input: the reduced fraction with the comparison flag in m_tdata and the
// divide-by-zero flag in m_tuser.
// s_tready is high only while the sequencer is idle; one request is worked at
// a time. A single multiplier forms the four products in the states MUL_L,
// MUL_R, MUL_P and MUL_D, then a binary GCD loop (one shift or subtract a
// cycle) and one restoring divider (one quotient bit a cycle, run twice, of
// width W = 2*OPERAND_WIDTH-1) reduce the fraction. Comparisons finish after
// the products. The next request is accepted at the earliest on the same
// edge as the earliest result accept.
// The result sits in an output register; a new request is taken while it
// waits, and a stalled receiver only holds the next result back once that
// one is ready. aresetn (synchronous, active low) returns the sequencer to
// idle and drops m_tvalid.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // a_num, a_den, b_num, b_den, zero pad
    input  logic [((4*OPERAND_WIDTH-2+7)/8)*8-1:0]      s_tdata,
    // operation
    input  logic [3:0]                                  s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // res_num, res_den, compare_true, zero pad
    output logic [63:0]                                 m_tdata,
    // div_by_zero
    output logic [0:0]                                  m_tuser
);

    localparam int N  = OPERAND_WIDTH;
    localparam int W  = 2 * N - 1;
    localparam int XW = (W > 32) ? W : 32;

    rau_pkg::state_t state_reg, state_next;
    rau_pkg::op_t    op_reg, op_next;

    logic         an_neg_reg, an_neg_next;
    logic [N-1:0] an_mag_reg, an_mag_next;
    logic [N-2:0] ad_reg, ad_next;
    logic         bn_neg_reg, bn_neg_next;
    logic [N-1:0] bn_mag_reg, bn_mag_next;
    logic [N-2:0] bd_reg, bd_next;

    logic [W-1:0] left_reg, left_next;
    logic [W-1:0] right_reg, right_next;
    logic [W-1:0] pn_reg, pn_next;
    logic [W-1:0] pd_reg, pd_next;

    logic [W-1:0] u_reg, u_next;
    logic [W-1:0] v_reg, v_next;
    logic [W-1:0] num_reg, num_next;
    logic [W-1:0] den_reg, den_next;
    logic         neg_reg, neg_next;
    logic         cmp_reg, cmp_next;
    logic         dz_reg, dz_next;
    logic [W-1:0] qn_reg, qn_next;
    logic [W-1:0] qd_reg, qd_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [rau_pkg::RES_NUM_W-1:0] out_num_reg, out_num_next;
    logic [rau_pkg::RES_DEN_W-1:0] out_den_reg, out_den_next;
    logic                          out_cmp_reg, out_cmp_next;
    logic                          out_dz_reg, out_dz_next;

    logic [N-1:0]   in_an, in_bn;
    logic [N-2:0]   in_ad, in_bd;
    logic [N-1:0]   mul_x, mul_y;
    logic [2*N-1:0] product;

    logic         div_start, div_done;
    logic [W-1:0] div_dividend, div_quotient;

    logic         sum_neg, r_neg;
    logic [W-1:0] sum_mag;
    logic signed [W:0] lv, rv;

    logic [XW-1:0]                 qn_ext, qd_ext;
    logic [rau_pkg::RES_NUM_W-2:0] fin_mag;
    logic [rau_pkg::RES_DEN_W-1:0] fin_den;

    assign in_an = s_tdata[N-1:0];
    assign in_ad = s_tdata[2*N-2:N];
    assign in_bn = s_tdata[3*N-2:2*N-1];
    assign in_bd = s_tdata[4*N-3:3*N-1];

    // shared multiplier
    always_comb begin
        mul_x = an_mag_reg;
        mul_y = {1'b0, bd_reg};
        unique case (state_reg)
            rau_pkg::ST_MUL_R: begin
                mul_x = bn_mag_reg;
                mul_y = {1'b0, ad_reg};
            end
            rau_pkg::ST_MUL_P: begin
                mul_x = an_mag_reg;
                mul_y = bn_mag_reg;
            end
            rau_pkg::ST_MUL_D: begin
                mul_x = {1'b0, ad_reg};
                mul_y = {1'b0, bd_reg};
            end
            default: begin
                mul_x = an_mag_reg;
                mul_y = {1'b0, bd_reg};
            end
        endcase
        product = mul_x * mul_y;
    end

    // signed sum of the cross products, sign of b flipped for subtract
    always_comb begin
        r_neg = (op_reg == rau_pkg::OP_SUB) ? ~bn_neg_reg : bn_neg_reg;
        if (an_neg_reg == r_neg) begin
            sum_neg = an_neg_reg;
            sum_mag = left_reg + right_reg;
        end else if (left_reg >= right_reg) begin
            sum_neg = an_neg_reg;
            sum_mag = left_reg - right_reg;
        end else begin
            sum_neg = r_neg;
            sum_mag = right_reg - left_reg;
        end
        lv = an_neg_reg ? -$signed({1'b0, left_reg})  : $signed({1'b0, left_reg});
        rv = bn_neg_reg ? -$signed({1'b0, right_reg}) : $signed({1'b0, right_reg});
    end

    // saturation of the reduced result
    always_comb begin
        qn_ext  = XW'(qn_reg);
        qd_ext  = XW'(qd_reg);
        fin_mag = (qn_ext > XW'(rau_pkg::NUM_SAT)) ? rau_pkg::NUM_SAT
                                                   : qn_ext[rau_pkg::RES_NUM_W-2:0];
        fin_den = (qd_ext > XW'(rau_pkg::DEN_SAT)) ? rau_pkg::DEN_SAT
                                                   : qd_ext[rau_pkg::RES_DEN_W-1:0];
    end

    assign div_dividend = (state_reg == rau_pkg::ST_GCD) ? num_reg : den_reg;

    rau_divider #(
        .WIDTH (W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (v_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        an_neg_next   = an_neg_reg;
        an_mag_next   = an_mag_reg;
        ad_next       = ad_reg;
        bn_neg_next   = bn_neg_reg;
        bn_mag_next   = bn_mag_reg;
        bd_next       = bd_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        pn_next       = pn_reg;
        pd_next       = pd_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        neg_next      = neg_reg;
        cmp_next      = cmp_reg;
        dz_next       = dz_reg;
        qn_next       = qn_reg;
        qd_next       = qd_reg;
        out_num_next  = out_num_reg;
        out_den_next  = out_den_reg;
        out_cmp_next  = out_cmp_reg;
        out_dz_next   = out_dz_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        div_start     = 1'b0;
        s_tready      = 1'b0;

        unique case (state_reg)
            rau_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next     = rau_pkg::op_t'(s_tuser);
                    an_neg_next = in_an[N-1];
                    an_mag_next = in_an[N-1] ? -in_an : in_an;
                    ad_next     = (in_ad == '0) ? (N-1)'(1) : in_ad;
                    bn_neg_next = in_bn[N-1];
                    bn_mag_next = in_bn[N-1] ? -in_bn : in_bn;
                    bd_next     = (in_bd == '0) ? (N-1)'(1) : in_bd;
                    state_next  = rau_pkg::ST_MUL_L;
                end
            end
            rau_pkg::ST_MUL_L: begin
                left_next  = product[W-1:0];
                state_next = rau_pkg::ST_MUL_R;
            end
            rau_pkg::ST_MUL_R: begin
                right_next = product[W-1:0];
                state_next = rau_pkg::ST_MUL_P;
            end
            rau_pkg::ST_MUL_P: begin
                pn_next    = product[W-1:0];
                state_next = rau_pkg::ST_MUL_D;
            end
            rau_pkg::ST_MUL_D: begin
                pd_next    = product[W-1:0];
                state_next = rau_pkg::ST_SETUP;
            end
            rau_pkg::ST_SETUP: begin
                neg_next   = 1'b0;
                cmp_next   = 1'b0;
                dz_next    = 1'b0;
                qn_next    = '0;
                qd_next    = '0;
                state_next = rau_pkg::ST_FIN;
                unique case (op_reg) inside
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                        neg_next   = sum_neg;
                        u_next     = sum_mag;
                        num_next   = sum_mag;
                        v_next     = pd_reg;
                        den_next   = pd_reg;
                        state_next = rau_pkg::ST_GCD;
                    end
                    rau_pkg::OP_MUL: begin
                        neg_next   = an_neg_reg ^ bn_neg_reg;
                        u_next     = pn_reg;
                        num_next   = pn_reg;
                        v_next     = pd_reg;
                        den_next   = pd_reg;
                        state_next = rau_pkg::ST_GCD;
                    end
                    rau_pkg::OP_DIV: begin
                        if (bn_mag_reg == '0) begin
                            dz_next = 1'b1;
                            qd_next = W'(1);
                        end else begin
                            neg_next   = an_neg_reg ^ bn_neg_reg;
                            u_next     = left_reg;
                            num_next   = left_reg;
                            v_next     = right_reg;
                            den_next   = right_reg;
                            state_next = rau_pkg::ST_GCD;
                        end
                    end
                    rau_pkg::OP_GT: cmp_next = lv > rv;
                    rau_pkg::OP_LT: cmp_next = lv < rv;
                    rau_pkg::OP_GE: cmp_next = lv >= rv;
                    rau_pkg::OP_LE: cmp_next = lv <= rv;
                    rau_pkg::OP_EQ: cmp_next = lv == rv;
                    rau_pkg::OP_NE: cmp_next = lv != rv;
                    default: cmp_next = 1'b0;
                endcase
            end
            rau_pkg::ST_GCD: begin
                // binary GCD; common factors of two are stripped from the
                // operands as well so that v ends as the full divisor
                if (u_reg == '0) begin
                    div_start  = 1'b1;
                    state_next = rau_pkg::ST_DIV_N;
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_next   = u_reg >> 1;
                    v_next   = v_reg >> 1;
                    num_next = num_reg >> 1;
                    den_next = den_reg >> 1;
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (u_reg >= v_reg) begin
                    u_next = u_reg - v_reg;
                end else begin
                    v_next = v_reg - u_reg;
                end
            end
            rau_pkg::ST_DIV_N: begin
                if (div_done) begin
                    qn_next    = div_quotient;
                    div_start  = 1'b1;
                    state_next = rau_pkg::ST_DIV_D;
                end
            end
            rau_pkg::ST_DIV_D: begin
                if (div_done) begin
                    qd_next    = div_quotient;
                    state_next = rau_pkg::ST_FIN;
                end
            end
            rau_pkg::ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_num_next  = (neg_reg && qn_reg != '0) ? -{1'b0, fin_mag}
                                                              : {1'b0, fin_mag};
                    out_den_next  = fin_den;
                    out_cmp_next  = cmp_reg;
                    out_dz_next   = dz_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = rau_pkg::ST_IDLE;
                end
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rau_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        an_neg_reg  <= an_neg_next;
        an_mag_reg  <= an_mag_next;
        ad_reg      <= ad_next;
        bn_neg_reg  <= bn_neg_next;
        bn_mag_reg  <= bn_mag_next;
        bd_reg      <= bd_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        pn_reg      <= pn_next;
        pd_reg      <= pd_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        neg_reg     <= neg_next;
        cmp_reg     <= cmp_next;
        dz_reg      <= dz_next;
        qn_reg      <= qn_next;
        qd_reg      <= qd_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
        out_cmp_reg <= out_cmp_next;
        out_dz_reg  <= out_dz_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_cmp_reg, out_den_reg, out_num_reg};
    assign m_tuser  = out_dz_reg;

`ifndef NO_ASSERTIONS
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == rau_pkg::ST_DIV_N || state_reg == rau_pkg::ST_DIV_D))
        else $error("divider finished outside a division step");

    a_gcd_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rau_pkg::ST_GCD |-> v_reg != '0)
        else $error("GCD divisor reached zero");

    a_dz_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_dz_reg |->
            out_num_reg == '0 && out_den_reg == rau_pkg::RES_DEN_W'(1) && !out_cmp_reg)
        else $error("divide by zero result is not 0/1");

    a_cmp_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_cmp_reg |-> out_num_reg == '0 && out_den_reg == '0)
        else $error("comparison result carries a fraction");

    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == rau_pkg::ST_MUL_L)
        else $error("accepted request did not start the products");
`endif

endmodule
